// ===== src/linear_blend_skinning_macros.svh =====
`ifndef LINEAR_BLEND_SKINNING_MACROS_SVH
`define LINEAR_BLEND_SKINNING_MACROS_SVH

// same-cycle implication
`define LBS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;

   localparam int MAX_BONES   = 256;
   localparam int MAT_ELEMS   = 12;
   localparam int BONE_AW     = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_SKIN  = 1'b1;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] nrm_x;
      logic signed [31:0] nrm_y;
      logic signed [31:0] nrm_z;
   } lbs_result_type;

   function automatic logic signed [31:0] blend_round(input logic signed [49:0] acc);
      logic signed [49:0] t;
      t = (acc + 50'sd16384) >>> 15;
      if (t > 50'sd2147483647)
         return 32'sh7fffffff;
      else if (t < -50'sd2147483648)
         return 32'sh80000000;
      else
         return t[31:0];
   endfunction

   function automatic logic signed [31:0] xf_round(input logic signed [31:0] tr,
                                                   input logic signed [63:0] p0,
                                                   input logic signed [63:0] p1,
                                                   input logic signed [63:0] p2);
      logic signed [65:0] s;
      s = (66'(tr) <<< 16) + 66'(p0) + 66'(p1) + 66'(p2) + 66'sd32768;
      s = s >>> 16;
      if (s > 66'sd2147483647)
         return 32'sh7fffffff;
      else if (s < -66'sd2147483648)
         return 32'sh80000000;
      else
         return s[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/linear_blend_skinning.sv =====
// four-bone linear blend skinning engine
// req channel: one word per valid/stall handshake. func 0 writes one palette
// element (entry_index, element_index, element_value) and gives no result;
// func 1 skins one vertex with four bone indices and Q1.15 weights.
// rsp channel: one word per skinned vertex, position and normal in Q16.16,
// in the order the vertices were taken.
// palette: twelve 256 x 32 memories, one per matrix element; one bone is read
// per cycle, so a vertex occupies the read port while its four bones are read,
// and a new item (vertex or write) is taken while the last of them is read.
// the blend is rounded, then applied row by row, and the result word is queued.
// reset empties the pipeline and result queue; palette contents stay
// undefined until written. the result queue holds 4 words; while 4 vertices
// are in flight or queued, req_stall rises for vertices until a word leaves.
`timescale 1ns / 1ps
`default_nettype none
module linear_blend_skinning
   import lbs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_func,
   input  wire logic [31:0]        req_bone_indices,
   input  wire logic [63:0]        req_bone_weights,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic signed [31:0] req_nrm_x,
   input  wire logic signed [31:0] req_nrm_y,
   input  wire logic signed [31:0] req_nrm_z,
   input  wire logic [7:0]         req_entry_index,
   input  wire logic [3:0]         req_element_index,
   input  wire logic signed [31:0] req_element_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_skinned_x,
   output logic signed [31:0]      rsp_skinned_y,
   output logic signed [31:0]      rsp_skinned_z,
   output logic signed [31:0]      rsp_normal_out_x,
   output logic signed [31:0]      rsp_normal_out_y,
   output logic signed [31:0]      rsp_normal_out_z
);

   // issue stage
   logic               iss_busy_ff, iss_busy_in;
   logic [1:0]         iss_k_ff, iss_k_in;
   logic [31:0]        vtx_idx_ff;
   logic [63:0]        vtx_w_ff;
   logic signed [31:0] vtx_vec_ff [6];

   // read stage
   logic               rd_vld_ff, rd_first_ff, rd_last_ff, rd_inr_ff;
   logic [15:0]        rd_w_ff;
   logic signed [31:0] rd_vec_ff [6];
   logic [31:0]        rd_data [MAT_ELEMS];

   // accumulate and blend
   logic signed [49:0] acc_ff [MAT_ELEMS];
   logic               done_ff;
   logic signed [31:0] blend_ff [MAT_ELEMS];
   logic signed [31:0] xf_vec_ff [6];

   // transform
   logic               xf_act_ff;
   logic [1:0]         xf_row_ff;
   logic               m_vld_ff;
   logic [1:0]         m_row_ff;
   logic signed [63:0] m_pp_ff [3];
   logic signed [63:0] m_np_ff [3];
   logic signed [31:0] m_tr_ff;
   logic signed [31:0] res_ff [4];

   // result queue
   lbs_result_type     q_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] q_wr_ff, q_rd_ff;
   logic [QUEUE_AW:0]  q_cnt_ff;
   logic [QUEUE_AW:0]  pend_ff;

   logic               can_take, req_acc, vtx_acc, wr_acc, rsp_acc, push;
   logic [7:0]         rd_idx;
   logic [BONE_AW-1:0] rd_addr;
   logic               wr_ok;
   logic signed [31:0] pos_r, nrm_r;
   lbs_result_type     push_word;

   assign can_take  = !iss_busy_ff || (iss_k_ff == 2'd3);
   assign req_stall = !can_take ||
                      (req_func == FUNC_SKIN && pend_ff >= (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign req_acc   = req_valid && !req_stall;
   assign vtx_acc   = req_acc && req_func == FUNC_SKIN;
   assign wr_acc    = req_acc && req_func == FUNC_WRITE;
   assign rsp_valid = q_cnt_ff != '0;
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign push      = m_vld_ff && m_row_ff == 2'd2;

   assign wr_ok   = wr_acc && (9'(req_entry_index) < 9'(MAX_BONES))
                    && (req_element_index < 4'(MAT_ELEMS));
   assign rd_idx  = vtx_idx_ff[8*iss_k_ff +: 8];
   assign rd_addr = rd_idx[BONE_AW-1:0];

   for (genvar e = 0; e < MAT_ELEMS; e++) begin : g_pal
      lbs_ram #(.WIDTH(32), .DEPTH(MAX_BONES)) u_ram (
         .clock   (clock),
         .wr_en   (wr_ok && req_element_index == 4'(e)),
         .wr_addr (req_entry_index[BONE_AW-1:0]),
         .wr_data (req_element_value),
         .rd_addr (rd_addr),
         .rd_data (rd_data[e])
      );
   end

   always_comb begin
      iss_busy_in = iss_busy_ff;
      iss_k_in    = iss_k_ff;
      if (vtx_acc) begin
         iss_busy_in = 1'b1;
         iss_k_in    = 2'd0;
      end else if (iss_busy_ff) begin
         iss_k_in = iss_k_ff + 2'd1;
         if (iss_k_ff == 2'd3) begin
            iss_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_busy_ff <= 1'b0;
         iss_k_ff    <= 2'd0;
      end else begin
         iss_busy_ff <= iss_busy_in;
         iss_k_ff    <= iss_k_in;
      end
      if (vtx_acc) begin
         vtx_idx_ff    <= req_bone_indices;
         vtx_w_ff      <= req_bone_weights;
         vtx_vec_ff[0] <= req_pos_x;
         vtx_vec_ff[1] <= req_pos_y;
         vtx_vec_ff[2] <= req_pos_z;
         vtx_vec_ff[3] <= req_nrm_x;
         vtx_vec_ff[4] <= req_nrm_y;
         vtx_vec_ff[5] <= req_nrm_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= iss_busy_ff;
      end
      rd_first_ff <= iss_k_ff == 2'd0;
      rd_last_ff  <= iss_k_ff == 2'd3;
      rd_inr_ff   <= 9'(rd_idx) < 9'(MAX_BONES);
      rd_w_ff     <= vtx_w_ff[16*iss_k_ff +: 16];
      if (iss_busy_ff && iss_k_ff == 2'd3) begin
         rd_vec_ff <= vtx_vec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= rd_vld_ff && rd_last_ff;
      end
      for (int e = 0; e < MAT_ELEMS; e++) begin
         if (rd_vld_ff) begin
            acc_ff[e] <= (rd_first_ff ? 50'sd0 : acc_ff[e])
                         + (rd_inr_ff ? 50'($signed(rd_data[e]) * $signed({1'b0, rd_w_ff}))
                                      : 50'sd0);
         end
      end
      if (done_ff) begin
         for (int e = 0; e < MAT_ELEMS; e++) begin
            blend_ff[e] <= blend_round(acc_ff[e]);
         end
         xf_vec_ff <= rd_vec_ff;
      end else if (xf_act_ff) begin
         for (int e = 0; e < MAT_ELEMS - 4; e++) begin
            blend_ff[e] <= blend_ff[e+4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xf_act_ff <= 1'b0;
         xf_row_ff <= 2'd0;
         m_vld_ff  <= 1'b0;
      end else begin
         if (done_ff) begin
            xf_act_ff <= 1'b1;
            xf_row_ff <= 2'd0;
         end else if (xf_act_ff) begin
            xf_row_ff <= xf_row_ff + 2'd1;
            if (xf_row_ff == 2'd2) begin
               xf_act_ff <= 1'b0;
            end
         end
         m_vld_ff <= xf_act_ff;
      end
      m_row_ff <= xf_row_ff;
      m_tr_ff  <= blend_ff[3];
      for (int c = 0; c < 3; c++) begin
         m_pp_ff[c] <= blend_ff[c] * xf_vec_ff[c];
         m_np_ff[c] <= blend_ff[c] * xf_vec_ff[3+c];
      end
   end

   always_comb begin
      pos_r = xf_round(m_tr_ff, m_pp_ff[0], m_pp_ff[1], m_pp_ff[2]);
      nrm_r = xf_round(32'sd0, m_np_ff[0], m_np_ff[1], m_np_ff[2]);
      push_word.pos_x = res_ff[0];
      push_word.nrm_x = res_ff[1];
      push_word.pos_y = res_ff[2];
      push_word.nrm_y = res_ff[3];
      push_word.pos_z = pos_r;
      push_word.nrm_z = nrm_r;
   end

   always_ff @(posedge clock) begin
      if (m_vld_ff && m_row_ff == 2'd0) begin
         res_ff[0] <= pos_r;
         res_ff[1] <= nrm_r;
      end
      if (m_vld_ff && m_row_ff == 2'd1) begin
         res_ff[2] <= pos_r;
         res_ff[3] <= nrm_r;
      end
      if (push) begin
         q_ff[q_wr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
         pend_ff  <= '0;
      end else begin
         if (push) begin
            q_wr_ff <= q_wr_ff + 1'b1;
         end
         if (rsp_acc) begin
            q_rd_ff <= q_rd_ff + 1'b1;
         end
         q_cnt_ff <= q_cnt_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(rsp_acc);
         pend_ff  <= pend_ff + (QUEUE_AW+1)'(vtx_acc) - (QUEUE_AW+1)'(rsp_acc);
      end
   end

   assign rsp_skinned_x    = q_ff[q_rd_ff].pos_x;
   assign rsp_skinned_y    = q_ff[q_rd_ff].pos_y;
   assign rsp_skinned_z    = q_ff[q_rd_ff].pos_z;
   assign rsp_normal_out_x = q_ff[q_rd_ff].nrm_x;
   assign rsp_normal_out_y = q_ff[q_rd_ff].nrm_y;
   assign rsp_normal_out_z = q_ff[q_rd_ff].nrm_z;

`include "linear_blend_skinning_macros.svh"

   `LBS_ASSERT_NOW(a_pend_cap, 1'b1, pend_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH), "pending over cap")
   `LBS_ASSERT_NOW(a_q_le_pend, 1'b1, q_cnt_ff <= pend_ff, "queue beyond pending count")
   `LBS_ASSERT_NEXT(a_xf_start, done_ff, xf_act_ff && xf_row_ff == 2'd0, "transform not started")
   `LBS_ASSERT_NEXT(a_push_vis, push, q_cnt_ff != '0, "pushed word not visible")

endmodule
`default_nettype wire

// ===== src/lbs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== bench/lbs_checker.sv =====
`timescale 1ns / 1ps
module lbs_checker
   import lbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_func,
   input  logic [31:0]        req_bone_indices,
   input  logic [63:0]        req_bone_weights,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_nrm_x,
   input  logic signed [31:0] req_nrm_y,
   input  logic signed [31:0] req_nrm_z,
   input  logic [7:0]         req_entry_index,
   input  logic [3:0]         req_element_index,
   input  logic signed [31:0] req_element_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_skinned_x,
   input  logic signed [31:0] rsp_skinned_y,
   input  logic signed [31:0] rsp_skinned_z,
   input  logic signed [31:0] rsp_normal_out_x,
   input  logic signed [31:0] rsp_normal_out_y,
   input  logic signed [31:0] rsp_normal_out_z,
   output int                 fails,
   output int                 pending
);

   logic signed [31:0] bone_mat [MAX_BONES][MAT_ELEMS];
   lbs_result_type skinned_q[$];

   function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
      if (x > 80'sd2147483647)
         return 32'sh7fffffff;
      else if (x < -80'sd2147483648)
         return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic lbs_result_type skin_vertex(input logic [31:0] idx4,
                                                  input logic [63:0] wgt4,
                                                  input logic signed [31:0] p [3],
                                                  input logic signed [31:0] n [3]);
      logic signed [31:0] bl [MAT_ELEMS];
      logic signed [79:0] acc, ps, ns;
      logic signed [31:0] po [3], no [3];
      logic signed [31:0] w;
      int idx;
      lbs_result_type res;
      for (int e = 0; e < MAT_ELEMS; e++) begin
         acc = 0;
         for (int k = 0; k < 4; k++) begin
            idx = idx4[8*k +: 8];
            w = {16'd0, wgt4[16*k +: 16]};
            if (idx < MAX_BONES)
               acc = acc + bone_mat[idx][e] * w;
         end
         bl[e] = sat32((acc + 80'sd16384) >>> 15);
      end
      for (int r = 0; r < 3; r++) begin
         ps = bl[r*4+3];
         ps = ps <<< 16;
         ns = 0;
         for (int c = 0; c < 3; c++) begin
            ps = ps + bl[r*4+c] * p[c];
            ns = ns + bl[r*4+c] * n[c];
         end
         po[r] = sat32((ps + 80'sd32768) >>> 16);
         no[r] = sat32((ns + 80'sd32768) >>> 16);
      end
      res.pos_x = po[0]; res.pos_y = po[1]; res.pos_z = po[2];
      res.nrm_x = no[0]; res.nrm_y = no[1]; res.nrm_z = no[2];
      return res;
   endfunction

   initial begin
      fails = 0;
      pending = 0;
      for (int i = 0; i < MAX_BONES; i++)
         for (int e = 0; e < MAT_ELEMS; e++)
            bone_mat[i][e] = 0;
   end

   always @(posedge clock) begin
      logic signed [31:0] p [3], n [3];
      logic signed [31:0] exp_v [6], got_v [6];
      lbs_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_SKIN) begin
               p = '{req_pos_x, req_pos_y, req_pos_z};
               n = '{req_nrm_x, req_nrm_y, req_nrm_z};
               skinned_q.push_back(skin_vertex(req_bone_indices, req_bone_weights, p, n));
            end else if (req_entry_index < MAX_BONES && req_element_index < MAT_ELEMS) begin
               bone_mat[req_entry_index][req_element_index] = req_element_value;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (skinned_q.size() == 0) begin
               $display("%0t: unexpected result word", $time);
               fails++;
            end else begin
               want = skinned_q.pop_front();
               exp_v = '{want.pos_x, want.pos_y, want.pos_z,
                         want.nrm_x, want.nrm_y, want.nrm_z};
               got_v = '{rsp_skinned_x, rsp_skinned_y, rsp_skinned_z,
                         rsp_normal_out_x, rsp_normal_out_y, rsp_normal_out_z};
               for (int f = 0; f < 6; f++)
                  if (exp_v[f] !== got_v[f]) begin
                     $display("%0t: field %0d expected %h actual %h",
                              $time, f, exp_v[f], got_v[f]);
                     fails++;
                  end
            end
         end
      end
      pending = skinned_q.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import lbs_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic               req_func = FUNC_WRITE;
   logic [31:0]        req_bone_indices = 0;
   logic [63:0]        req_bone_weights = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [31:0] req_nrm_x = 0, req_nrm_y = 0, req_nrm_z = 0;
   logic [7:0]         req_entry_index = 0;
   logic [3:0]         req_element_index = 0;
   logic signed [31:0] req_element_value = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [31:0] rsp_skinned_x, rsp_skinned_y, rsp_skinned_z;
   logic signed [31:0] rsp_normal_out_x, rsp_normal_out_y, rsp_normal_out_z;
   int                 fails, pending;

   bit                 calm = 0;
   logic [11:0]        elem_done [MAX_BONES];
   int                 ready_q[$];
   int                 n_vert = 0, n_write = 0;

   linear_blend_skinning u_top (.*);

   lbs_checker u_checker (.*);

   initial forever #6 clock = ~clock;

   initial begin
      #5ms;
      $display("linear_blend_skinning regression: fail");
      $finish;
   end

   always @(negedge clock)
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 30);

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h00010000;
         3: return 32'hffff0000;
         4: return 32'h0;
         5, 6: return $urandom_range(0, 32'h3ffff) - 32'h20000;
         default: return $urandom;
      endcase
   endfunction

   // hold one word on the bus until taken
   task automatic put_word();
      if (!calm)
         while ($urandom_range(0, 99) < 30) begin
            req_valid = 0;
            @(negedge clock);
         end
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic write_elem(input int ent, input int el, input logic [31:0] val);
      req_func = FUNC_WRITE;
      req_entry_index = 8'(ent);
      req_element_index = 4'(el);
      req_element_value = val;
      req_bone_indices = $urandom;
      req_pos_x = $urandom;
      put_word();
      n_write++;
      if (el < MAT_ELEMS) begin
         elem_done[ent][el] = 1'b1;
         if (elem_done[ent] == 12'hfff && !(ent inside {ready_q}))
            ready_q.push_back(ent);
      end
   endtask

   task automatic skin(input logic [31:0] idx, input logic [63:0] wgt,
                       input logic [31:0] px, py, pz, nx, ny, nz);
      req_func = FUNC_SKIN;
      req_bone_indices = idx;
      req_bone_weights = wgt;
      req_pos_x = px; req_pos_y = py; req_pos_z = pz;
      req_nrm_x = nx; req_nrm_y = ny; req_nrm_z = nz;
      req_entry_index = 8'($urandom);
      req_element_index = 4'($urandom);
      req_element_value = $urandom;
      put_word();
      n_vert++;
   endtask

   function automatic logic [31:0] pick_bones();
      logic [31:0] idx;
      for (int k = 0; k < 4; k++)
         idx[8*k +: 8] = 8'(ready_q[$urandom_range(0, ready_q.size() - 1)]);
      return idx;
   endfunction

   function automatic logic [63:0] pick_weights();
      logic [63:0] w;
      case ($urandom_range(0, 3))
         0: w = 64'h8000 << (16 * $urandom_range(0, 3));
         1: w = 64'h2000_2000_2000_2000;
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   initial begin
      int ent;
      for (int i = 0; i < MAX_BONES; i++)
         elem_done[i] = 0;
      repeat (7) @(negedge clock);
      reset = 0;

      // palette setup: identity, all-max, all-min, and random matrices
      for (int e = 0; e < MAT_ELEMS; e++) begin
         write_elem(0, e, (e % 5 == 0) ? 32'h00010000 : 32'h0);
         write_elem(255, e, 32'h7fffffff);
         write_elem(1, e, 32'h80000000);
      end
      for (int b = 2; b < 8; b++)
         for (int e = 0; e < MAT_ELEMS; e++)
            write_elem(b * 37 % 256, e, pick_value());

      // directed vertices and out-of-range element writes
      skin(32'h0, 64'h8000, 32'h00010000, 32'h00020000, 32'h00030000,
           32'h00010000, 32'h0, 32'h0);
      skin(32'hffffffff, 64'hffffffffffffffff, 32'h7fffffff, 32'h7fffffff,
           32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
      skin(32'h01010101, 64'hffffffffffffffff, 32'h7fffffff, 32'h80000000,
           32'h1, 32'h80000000, 32'h7fffffff, 32'hffffffff);
      skin(32'h00ff0100, 64'h0, 32'h12345678, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0);
      skin(32'h01ff, 64'h0001_0001, 32'h1, 32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h8000);
      skin(32'h4a6f94ff, 64'h1000_3000_2000_2000, 32'h00008000, 32'hffff8000,
           32'h00018000, 32'h00007fff, 32'h0, 32'h80000000);
      write_elem(3, 12, 32'h7fffffff);
      write_elem(3, 15, 32'h80000000);
      skin(32'h00000000, 64'h8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);

      // random traffic
      for (int i = 0; i < 1050; i++) begin
         calm = (i >= 700 && i < 950);
         case ($urandom_range(0, 19))
            0: begin
               ent = $urandom_range(0, 255);
               for (int e = 0; e < MAT_ELEMS; e++)
                  write_elem(ent, e, pick_value());
            end
            1, 2, 3, 4:
               write_elem(ready_q.size() > 0 && $urandom_range(0, 1) ?
                          ready_q[$urandom_range(0, ready_q.size() - 1)] :
                          $urandom_range(0, 255),
                          $urandom_range(0, 15), pick_value());
            default:
               skin(pick_bones(), pick_weights(), pick_value(), pick_value(),
                    pick_value(), pick_value(), pick_value(), pick_value());
         endcase
      end

      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      $display("covered %0d skinned vertices and %0d palette writes, %0d matrices in use",
               n_vert, n_write, ready_q.size());
      if (fails == 0 && pending == 0)
         $display("linear_blend_skinning regression: pass");
      else
         $display("linear_blend_skinning regression: fail");
      $finish;
   end

endmodule
